### rtl/core/assert_macros.svh
// Assertion helpers for the day count checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property on clk, off while in reset.
`define CHK_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication on clk, off while in reset.
`define CHK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/core/t360_pkg.sv
package t360_pkg;

    localparam int YEAR_W     = 12;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int COUNT_W    = 18;
    localparam int CONV_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // y / 100 == (y * 5243) >> 19, exact for any 12-bit y
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int PROD_W       = 25;
    localparam int QUOT_W       = PROD_W - DIV100_SHIFT;

    localparam int DAYS_YEAR  = 360;
    localparam int DAYS_MONTH = 30;

    // raw sum width: 360 * 4095 needs 21 bits plus sign and headroom
    localparam int SUM_W = 23;

    localparam logic [YEAR_W-1:0]  TERM_YEAR_RST  = YEAR_W'(1901);
    localparam logic [MONTH_W-1:0] TERM_MONTH_RST = MONTH_W'(1);
    localparam logic [DAY_W-1:0]   TERM_DAY_RST   = DAY_W'(1);

    typedef enum logic [CONV_W-1:0] {
        CONV_US      = 3'd0,
        CONV_ISMA    = 3'd1,
        CONV_EURO    = 3'd2,
        CONV_ITALIAN = 3'd3,
        CONV_ISDA    = 3'd4,
        CONV_NASD    = 3'd5
    } conv_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_CONV       = 3'd0,
        IDX_TERM_SET   = 3'd1,
        IDX_TERM_YEAR  = 3'd2,
        IDX_TERM_MONTH = 3'd3,
        IDX_TERM_DAY   = 3'd4,
        IDX_LAST       = 3'd5
    } cfg_idx_t;

endpackage

### rtl/core/thirty_360_day_count_top.sv
// thirty_360_day_count_top: signed 30/360 day count between two dates.
// From input transfer to result valid, a date pair passes through the s1, s2 and output registers.
// Throughput: one date pair per cycle; each stage moves on as soon as the next
//   one frees up, so bubbles are squeezed out and input stalls only once all
//   three stages are full behind a stalled result.
// Reset (rst_n, async, active low): clears all stage valid bits and returns
//   the config registers to US, no termination date, 1901-01-01, not last.
module thirty_360_day_count_top
    import t360_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // config write channel, always ready
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // date pair input
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [YEAR_W-1:0]     start_year,
    input  logic [MONTH_W-1:0]    start_month,
    input  logic [DAY_W-1:0]      start_day,
    input  logic [YEAR_W-1:0]     end_year,
    input  logic [MONTH_W-1:0]    end_month,
    input  logic [DAY_W-1:0]      end_day,

    // day count output
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [COUNT_W-1:0] accrual_days
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CONV_W-1:0]  conv_reg;
    logic               term_set_reg;
    logic [YEAR_W-1:0]  term_year_reg;
    logic [MONTH_W-1:0] term_month_reg;
    logic [DAY_W-1:0]   term_day_reg;
    logic               last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_reg       <= CONV_US;
            term_set_reg   <= 1'b0;
            term_year_reg  <= TERM_YEAR_RST;
            term_month_reg <= TERM_MONTH_RST;
            term_day_reg   <= TERM_DAY_RST;
            last_reg       <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // indexes past the register list are dropped
            unique case (cfg_idx_t'(cfg_index))
                IDX_CONV:       conv_reg       <= cfg_data[CONV_W-1:0];
                IDX_TERM_SET:   term_set_reg   <= cfg_data[0];
                IDX_TERM_YEAR:  term_year_reg  <= cfg_data[YEAR_W-1:0];
                IDX_TERM_MONTH: term_month_reg <= cfg_data[MONTH_W-1:0];
                IDX_TERM_DAY:   term_day_reg   <= cfg_data[DAY_W-1:0];
                IDX_LAST:       last_reg       <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: each stage loads when it is empty or when the
    // stage after it moves on.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic ld1, ld2, ld3;

    assign ld3      = !out_valid_reg || !out_stall;
    assign ld2      = !s2_valid_reg  || ld3;
    assign ld1      = !s1_valid_reg  || ld2;
    assign in_stall = !ld1;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (ld2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ld3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the dates, year / 100 by reciprocal multiply,
    // termination date match on the raw end date, or the last flag when no termination date is set.
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]  y1_prod, y2_prod;
    logic               term_next;

    logic [YEAR_W-1:0]  s1_y1_reg, s1_y2_reg;
    logic [MONTH_W-1:0] s1_m1_reg, s1_m2_reg;
    logic [DAY_W-1:0]   s1_d1_reg, s1_d2_reg;
    logic [QUOT_W-1:0]  s1_q1_reg, s1_q2_reg;
    logic               s1_term_reg;

    assign y1_prod = PROD_W'(start_year) * PROD_W'(DIV100_MUL);
    assign y2_prod = PROD_W'(end_year)   * PROD_W'(DIV100_MUL);

    always_comb
    begin
        if (term_set_reg)
        begin
            term_next = (end_year == term_year_reg) && (end_month == term_month_reg)
                        && (end_day == term_day_reg);
        end
        else
        begin
            term_next = last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_y1_reg   <= start_year;
            s1_m1_reg   <= start_month;
            s1_d1_reg   <= start_day;
            s1_y2_reg   <= end_year;
            s1_m2_reg   <= end_month;
            s1_d2_reg   <= end_day;
            s1_q1_reg   <= y1_prod[PROD_W-1:DIV100_SHIFT];
            s1_q2_reg   <= y2_prod[PROD_W-1:DIV100_SHIFT];
            s1_term_reg <= term_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: Gregorian leap test, last-of-February flags, and the day /
    // month adjustments of the selected convention.
    // ------------------------------------------------------------------
    logic [YEAR_W-1:0]  r1, r2;
    logic               leap1, leap2;
    logic               lf1, lf2;
    logic [DAY_W-1:0]   d1_adj, d2_adj;
    logic [MONTH_W:0]   m2_adj;

    logic [YEAR_W-1:0]  s2_y1_reg, s2_y2_reg;
    logic [MONTH_W-1:0] s2_m1_reg;
    logic [MONTH_W:0]   s2_m2_reg;
    logic [DAY_W-1:0]   s2_d1_reg, s2_d2_reg;

    // remainder of y / 100
    assign r1 = s1_y1_reg - YEAR_W'(s1_q1_reg) * YEAR_W'(100);
    assign r2 = s1_y2_reg - YEAR_W'(s1_q2_reg) * YEAR_W'(100);

    // divisible by 4, and not a century unless the century is divisible by 4
    assign leap1 = (s1_y1_reg[1:0] == 2'd0) && ((r1 != '0) || (s1_q1_reg[1:0] == 2'd0));
    assign leap2 = (s1_y2_reg[1:0] == 2'd0) && ((r2 != '0) || (s1_q2_reg[1:0] == 2'd0));

    assign lf1 = (s1_m1_reg == MONTH_W'(2))
                 && (s1_d1_reg == (leap1 ? DAY_W'(29) : DAY_W'(28)));
    assign lf2 = (s1_m2_reg == MONTH_W'(2))
                 && (s1_d2_reg == (leap2 ? DAY_W'(29) : DAY_W'(28)));

    always_comb
    begin
        d1_adj = s1_d1_reg;
        d2_adj = s1_d2_reg;
        m2_adj = {1'b0, s1_m2_reg};

        // every convention maps a start day of 31 to 30
        if (s1_d1_reg == DAY_W'(31))
        begin
            d1_adj = DAY_W'(DAYS_MONTH);
        end

        unique case (conv_t'(conv_reg))
            CONV_ISMA:
            begin
                if (s1_d2_reg == DAY_W'(31) && d1_adj == DAY_W'(30))
                begin
                    d2_adj = DAY_W'(DAYS_MONTH);
                end
            end
            CONV_EURO:
            begin
                if (s1_d2_reg == DAY_W'(31))
                begin
                    d2_adj = DAY_W'(DAYS_MONTH);
                end
            end
            CONV_ITALIAN:
            begin
                if (s1_d2_reg == DAY_W'(31))
                begin
                    d2_adj = DAY_W'(DAYS_MONTH);
                end
                // late February counts as day 30 on either side
                if (s1_m1_reg == MONTH_W'(2) && d1_adj > DAY_W'(27))
                begin
                    d1_adj = DAY_W'(DAYS_MONTH);
                end
                if (s1_m2_reg == MONTH_W'(2) && d2_adj > DAY_W'(27))
                begin
                    d2_adj = DAY_W'(DAYS_MONTH);
                end
            end
            CONV_ISDA:
            begin
                if (s1_d2_reg == DAY_W'(31))
                begin
                    d2_adj = DAY_W'(DAYS_MONTH);
                end
                if (lf1)
                begin
                    d1_adj = DAY_W'(DAYS_MONTH);
                end
                // end of February is kept on the termination date
                if (!s1_term_reg && lf2)
                begin
                    d2_adj = DAY_W'(DAYS_MONTH);
                end
            end
            CONV_NASD:
            begin
                if (s1_d2_reg == DAY_W'(31))
                begin
                    if (d1_adj >= DAY_W'(30))
                    begin
                        d2_adj = DAY_W'(DAYS_MONTH);
                    end
                    else
                    begin
                        // roll to the first of the next month
                        d2_adj = DAY_W'(1);
                        m2_adj = {1'b0, s1_m2_reg} + (MONTH_W+1)'(1);
                    end
                end
            end
            default:
            begin
                // US, also for the unused codes
                if (s1_d2_reg == DAY_W'(31) && d1_adj >= DAY_W'(30))
                begin
                    d2_adj = DAY_W'(DAYS_MONTH);
                end
                if (lf1 && lf2)
                begin
                    d2_adj = DAY_W'(DAYS_MONTH);
                end
                if (lf1)
                begin
                    d1_adj = DAY_W'(DAYS_MONTH);
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            s2_y1_reg <= s1_y1_reg;
            s2_y2_reg <= s1_y2_reg;
            s2_m1_reg <= s1_m1_reg;
            s2_m2_reg <= m2_adj;
            s2_d1_reg <= d1_adj;
            s2_d2_reg <= d2_adj;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: 360*dY + 30*dM + dD, saturated to the output width.
    // ------------------------------------------------------------------
    logic signed [YEAR_W:0]    dy;
    logic signed [MONTH_W+1:0] dm;
    logic signed [DAY_W:0]     dd;
    logic signed [SUM_W-1:0]   dy_x, dm_x, dd_x, cnt;
    logic signed [COUNT_W-1:0] count_next;
    logic signed [COUNT_W-1:0] accrual_days_reg;

    localparam logic signed [SUM_W-1:0] CNT_MAX = SUM_W'((2 ** (COUNT_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] CNT_MIN = -SUM_W'(2 ** (COUNT_W - 1));

    assign dy   = $signed({1'b0, s2_y2_reg}) - $signed({1'b0, s2_y1_reg});
    assign dm   = $signed({1'b0, s2_m2_reg}) - $signed({2'b0, s2_m1_reg});
    assign dd   = $signed({1'b0, s2_d2_reg}) - $signed({1'b0, s2_d1_reg});
    assign dy_x = SUM_W'(dy);
    assign dm_x = SUM_W'(dm);
    assign dd_x = SUM_W'(dd);
    assign cnt  = dy_x * SUM_W'(DAYS_YEAR) + dm_x * SUM_W'(DAYS_MONTH) + dd_x;

    always_comb
    begin
        priority if (cnt > CNT_MAX)
        begin
            count_next = CNT_MAX[COUNT_W-1:0];
        end
        else if (cnt < CNT_MIN)
        begin
            count_next = CNT_MIN[COUNT_W-1:0];
        end
        else
        begin
            count_next = cnt[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            accrual_days_reg <= count_next;
        end
    end

    assign accrual_days = accrual_days_reg;

endmodule

### rtl/core/t360_checker.sv
`include "assert_macros.svh"

module t360_checker
    import t360_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [COUNT_W-1:0] accrual_days
);

    // a held result keeps its value
    `CHK_IMPL(a_out_hold, out_valid && out_stall, ##1 (out_valid && $stable(accrual_days)), "result changed while stalled")

    // input backs up only when the output end is full and stalled
    `CHK_IMPL(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with output free")

    // with a free-running output, a transfer moves through s1 and s2 and comes out of the output register
    `CHK_PROP(a_latency, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid, "result missing after three cycles")

endmodule

bind thirty_360_day_count_top t360_checker u_t360_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accrual_days (accrual_days)
);
